### rtl/core/pif_pkg.sv
// ----------------------------------------------------------------------------
// pif_pkg
// shared field widths and codes for the primitive index fetch block
// ----------------------------------------------------------------------------
package pif_pkg;

    // field widths of the channels
    localparam int FUNC_W  = 1;
    localparam int EADDR_W = 12;
    localparam int VALUE_W = 32;
    localparam int PRIM_W  = 12;

    // element number and start + element sum: 3 * 4095 + 2 + 4095 < 2**14
    localparam int ELEM_W = 14;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TOPOLOGY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ELEMENT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_VERTEX   = 2'd3;

    // topology codes
    localparam logic [1:0] TOPO_LINE_LIST = 2'd0;
    localparam logic [1:0] TOPO_LINE_STRIP = 2'd1;
    localparam logic [1:0] TOPO_TRI_LIST  = 2'd2;
    localparam logic [1:0] TOPO_TRI_STRIP = 2'd3;

    // index mode codes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_R16  = 2'd1;
    localparam logic [1:0] MODE_R32  = 2'd2;

    // input function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

endpackage

### rtl/core/pif_in_if.sv
// ----------------------------------------------------------------------------
// pif_in_if
// input channel: load and fetch beats with valid / ready
// ----------------------------------------------------------------------------
interface pif_in_if import pif_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [EADDR_W-1:0] entry_address;
    logic [VALUE_W-1:0] entry_value;
    logic [PRIM_W-1:0]  prim_id;
    logic               first_of_batch;

    modport source
    (
        output valid, func, entry_address, entry_value, prim_id, first_of_batch,
        input  ready
    );

    modport sink
    (
        input  valid, func, entry_address, entry_value, prim_id, first_of_batch,
        output ready
    );

endinterface

### rtl/core/pif_out_if.sv
// ----------------------------------------------------------------------------
// pif_out_if
// output channel: one vertex result per beat with valid / ready
// ----------------------------------------------------------------------------
interface pif_out_if import pif_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] vertex_index;
    logic [VALUE_W-1:0] low_index;
    logic [VALUE_W-1:0] high_index;
    logic               last_vertex;

    modport source
    (
        output valid, vertex_index, low_index, high_index, last_vertex,
        input  ready
    );

    modport sink
    (
        input  valid, vertex_index, low_index, high_index, last_vertex,
        output ready
    );

endinterface

### rtl/core/pif_ram.sv
// ----------------------------------------------------------------------------
// pif_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pif_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/primitive_index_fetch.sv
// ----------------------------------------------------------------------------
// primitive_index_fetch
// input assembler index fetch: local index store, topology expansion,
// base vertex bias and running min / max of the raw indices
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | beat
//  ---------+-----+---------------+---------------------------------------------
//  in_ch    | in  | valid / ready | func, entry_address, entry_value, prim_id,
//           |     |               | first_of_batch
//  out_ch   | out | valid / ready | vertex_index, low_index, high_index, last_vertex
//  cfg      | in  | cfg_we        | cfg_index, cfg_data (write only)
//
//  sequence: one item at a time; a load passes accept, two address reduction
//    steps and the store write; a non-indexed fetch sends its n vertices after
//    accept, an indexed fetch after two reduction steps, n reads and a wait,
//    n = 2 or 3, one by one through the single store read port and result register
//  reset: control state, running min (all ones), running max (zero) and the
//    config registers clear at once; the index store holds no reset
//  stalls: the result register holds while out_ch.ready is low; the last
//    vertex of a primitive waits there while the next beat is accepted
//
module primitive_index_fetch
    import pif_pkg::*;
#(
    parameter int STORE_DEPTH = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pif_in_if.sink                in_ch,
    pif_out_if.source             out_ch
);

    // address width of the index store
    localparam int AW = $clog2(STORE_DEPTH);

    // store address = sum mod STORE_DEPTH through a reciprocal multiply;
    // the quotient estimate is exact or one low, fixed by one subtract
    localparam int SH     = ELEM_W + AW;
    localparam int P1W    = 2 * ELEM_W + 1;
    localparam int QDW    = ELEM_W + AW + 1;
    localparam int RW     = ((ELEM_W > AW) ? ELEM_W : AW) + 1;
    localparam logic [63:0] RECIP_FULL = (64'd1 << SH) / STORE_DEPTH;
    localparam logic [ELEM_W:0] RECIP_M = RECIP_FULL[ELEM_W:0];

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RED1  = 3'd1;
    localparam logic [2:0] S_RED2  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // configuration
    logic [1:0]         topology_reg;
    logic [1:0]         index_mode_reg;
    logic [EADDR_W-1:0] start_reg;
    logic [VALUE_W-1:0] base_reg;

    // sequencer and item context
    logic [2:0]         state_reg, state_next;
    logic               is_load_reg, is_load_next;
    logic               nonidx_reg, nonidx_next;
    logic               swap_reg, swap_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [1:0]         k_reg, k_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [ELEM_W-1:0]  x_reg, x_next;
    logic [ELEM_W-1:0]  q_reg, q_next;
    logic [AW-1:0]      addr_reg, addr_next;

    // read response tracking
    logic               rsp_valid_reg, rsp_valid_next;
    logic [1:0]         rsp_k_reg, rsp_k_next;

    // per-vertex raw values and running range
    logic [VALUE_W-1:0] slot_reg [3];
    logic [VALUE_W-1:0] slot_next [3];
    logic [VALUE_W-1:0] min_reg, min_next;
    logic [VALUE_W-1:0] max_reg, max_next;

    // result register
    logic               ovalid_reg, ovalid_next;
    logic [VALUE_W-1:0] ovi_reg, ovi_next;
    logic [VALUE_W-1:0] omin_reg, omin_next;
    logic [VALUE_W-1:0] omax_reg, omax_next;
    logic               olast_reg, olast_next;

    // store port
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    logic               in_acc;
    logic               load_out;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign load_out    = (state_reg == S_OUT) && (!ovalid_reg || out_ch.ready);

    assign out_ch.valid        = ovalid_reg;
    assign out_ch.vertex_index = ovi_reg;
    assign out_ch.low_index    = omin_reg;
    assign out_ch.high_index   = omax_reg;
    assign out_ch.last_vertex  = olast_reg;

    pif_ram
    #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    )
    u_store
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (value_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign mem_we    = (state_reg == S_WRITE);
    assign mem_re    = (state_reg == S_READ);
    assign mem_waddr = addr_reg;
    assign mem_raddr = addr_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topology_reg   <= TOPO_LINE_LIST;
            index_mode_reg <= MODE_NONE;
            start_reg      <= '0;
            base_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOPOLOGY:      topology_reg   <= cfg_data[1:0];
                CFG_INDEX_MODE:    index_mode_reg <= cfg_data[1:0];
                CFG_START_ELEMENT: start_reg      <= cfg_data[EADDR_W-1:0];
                CFG_BASE_VERTEX:   base_reg       <= cfg_data[VALUE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        logic [ELEM_W-1:0]  e0;
        logic [P1W-1:0]     prod1;
        logic [QDW-1:0]     qd;
        logic [ELEM_W-1:0]  rem;
        logic [RW-1:0]      rem_ext;
        logic [AW:0]        addr_inc;
        logic [VALUE_W-1:0] raw;
        logic [1:0]         wslot;

        state_next     = state_reg;
        is_load_next   = is_load_reg;
        nonidx_next    = nonidx_reg;
        swap_next      = swap_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        value_next     = value_reg;
        x_next         = x_reg;
        q_next         = q_reg;
        addr_next      = addr_reg;
        rsp_valid_next = 1'b0;
        rsp_k_next     = rsp_k_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        ovalid_next    = ovalid_reg;
        ovi_next       = ovi_reg;
        omin_next      = omin_reg;
        omax_next      = omax_reg;
        olast_next     = olast_reg;
        for (int i = 0; i < 3; i++)
        begin
            slot_next[i] = slot_reg[i];
        end

        // first element number of the primitive; the rest follow in order
        case (topology_reg)
            TOPO_LINE_LIST: e0 = {1'b0, in_ch.prim_id, 1'b0};
            TOPO_TRI_LIST:  e0 = {1'b0, in_ch.prim_id, 1'b0} + ELEM_W'(in_ch.prim_id);
            default:        e0 = ELEM_W'(in_ch.prim_id);
        endcase

        // address reduction datapath
        prod1    = P1W'(x_reg) * P1W'(RECIP_M);
        qd       = QDW'(q_reg) * QDW'(STORE_DEPTH);
        rem      = x_reg - qd[ELEM_W-1:0];
        rem_ext  = RW'(rem);
        if (rem_ext >= RW'(STORE_DEPTH))
        begin
            rem_ext = rem_ext - RW'(STORE_DEPTH);
        end
        addr_inc = {1'b0, addr_reg} + (AW+1)'(1);

        // read response: mask, track range, park in its vertex slot
        raw   = (index_mode_reg == MODE_R16) ? {16'h0000, mem_rdata[15:0]} : mem_rdata;
        wslot = swap_reg ? (2'd2 - rsp_k_reg) : rsp_k_reg;
        if (rsp_valid_reg)
        begin
            slot_next[wslot] = raw;
            if (raw < min_reg)
            begin
                min_next = raw;
            end
            if (raw > max_reg)
            begin
                max_next = raw;
            end
        end

        // result register drains independently of the sequencer
        if (out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    is_load_next = (in_ch.func == FUNC_LOAD);
                    nonidx_next  = (index_mode_reg == MODE_NONE);
                    cnt_next     = topology_reg[1] ? 2'd3 : 2'd2;
                    swap_next    = (topology_reg == TOPO_TRI_STRIP) && in_ch.prim_id[0];
                    value_next   = in_ch.entry_value;
                    k_next       = 2'd0;
                    if (in_ch.func == FUNC_LOAD)
                    begin
                        x_next     = ELEM_W'(in_ch.entry_address);
                        state_next = S_RED1;
                    end
                    else if (index_mode_reg == MODE_NONE)
                    begin
                        // element numbers are the vertex indices
                        for (int i = 0; i < 3; i++)
                        begin
                            slot_next[(topology_reg == TOPO_TRI_STRIP && in_ch.prim_id[0])
                                      ? (2 - i) : i] = VALUE_W'(e0 + ELEM_W'(i));
                        end
                        state_next = S_OUT;
                    end
                    else
                    begin
                        if (in_ch.first_of_batch)
                        begin
                            min_next = '1;
                            max_next = '0;
                        end
                        x_next     = ELEM_W'(start_reg) + e0;
                        state_next = S_RED1;
                    end
                end
            end

            S_RED1:
            begin
                q_next     = ELEM_W'(prod1 >> SH);
                state_next = S_RED2;
            end

            S_RED2:
            begin
                addr_next  = rem_ext[AW-1:0];
                state_next = is_load_reg ? S_WRITE : S_READ;
            end

            S_WRITE:
            begin
                state_next = S_IDLE;
            end

            S_READ:
            begin
                // consecutive elements: bump the address with wrap
                addr_next      = (addr_inc == (AW+1)'(STORE_DEPTH)) ? '0 : addr_inc[AW-1:0];
                rsp_valid_next = 1'b1;
                rsp_k_next     = k_reg;
                if (k_reg == cnt_reg - 2'd1)
                begin
                    k_next     = 2'd0;
                    state_next = S_WAIT;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end

            S_WAIT:
            begin
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (load_out)
                begin
                    ovalid_next = 1'b1;
                    ovi_next    = slot_reg[k_reg] + base_reg;
                    omin_next   = nonidx_reg ? '0 : (min_reg + base_reg);
                    omax_next   = nonidx_reg ? '0 : (max_reg + base_reg);
                    olast_next  = (k_reg == cnt_reg - 2'd1);
                    if (k_reg == cnt_reg - 2'd1)
                    begin
                        k_next     = 2'd0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and running range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= 2'd0;
            rsp_valid_reg <= 1'b0;
            ovalid_reg    <= 1'b0;
            min_reg       <= '1;
            max_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
            ovalid_reg    <= ovalid_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
        end
    end

    // payload and item context
    always_ff @(posedge clk)
    begin
        is_load_reg <= is_load_next;
        nonidx_reg  <= nonidx_next;
        swap_reg    <= swap_next;
        cnt_reg     <= cnt_next;
        value_reg   <= value_next;
        x_reg       <= x_next;
        q_reg       <= q_next;
        addr_reg    <= addr_next;
        rsp_k_reg   <= rsp_k_next;
        ovi_reg     <= ovi_next;
        omin_reg    <= omin_next;
        omax_reg    <= omax_next;
        olast_reg   <= olast_next;
        for (int i = 0; i < 3; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    // store is never written and read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
        else $error("index store written and read in the same cycle");

    // read data only arrives while the read phase is open
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (state_reg == S_READ || state_reg == S_WAIT))
        else $error("store read response outside the read phase");

    // an indexed primitive has read at least one index before results go out
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !nonidx_reg) |-> (min_reg <= max_reg))
        else $error("running range empty at result time");

    // the last vertex of a primitive frees the input side next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && (k_reg == cnt_reg - 2'd1)) |=> (state_reg == S_IDLE))
        else $error("sequencer not idle after last vertex");

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for primitive_index_fetch: a local model of the index
// store, topology expansion, base vertex bias and running min / max predicts
// every vertex beat; random idling on both channels plus one long output hold
// ----------------------------------------------------------------------------
module tb
    import pif_pkg::*;
();

    localparam int STORE_DEPTH = 4096;

    // index mode code three is not named in the package, it behaves as r32
    localparam logic [1:0] MODE_R32_ALIAS = 2'd3;

    // one expected vertex beat on the output channel
    typedef struct packed {
        logic [VALUE_W-1:0] vertex_index;
        logic [VALUE_W-1:0] low_index;
        logic [VALUE_W-1:0] high_index;
        logic               last_vertex;
    } vertex_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pif_in_if  in_ch ();
    pif_out_if out_ch ();

    primitive_index_fetch #(
        .STORE_DEPTH (STORE_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #4 clk = ~clk;

    // shadow of the block: index store, running bounds, config registers
    logic [VALUE_W-1:0] store_shadow [STORE_DEPTH];
    bit                 store_written [STORE_DEPTH];
    logic [VALUE_W-1:0] run_min = '1;
    logic [VALUE_W-1:0] run_max = '0;
    logic [1:0]         cfg_topo = TOPO_LINE_LIST;
    logic [1:0]         cfg_mode = MODE_NONE;
    logic [EADDR_W-1:0] cfg_start = '0;
    logic [VALUE_W-1:0] cfg_base = '0;

    // vertex beats predicted but not yet seen, oldest first
    vertex_beat_t pending_vertices [$];
    vertex_beat_t head_vertex;

    int err_count  = 0;
    int beats_sent = 0;
    bit idle_on    = 1'b1;
    int hold_left  = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("[%0t] mismatch: %s got 0x%08h want 0x%08h", $time, what, got, want);
    endtask

    // element numbers of one primitive for the current topology
    function automatic int prim_elements(input logic [PRIM_W-1:0] prim,
                                         output logic [2:0][ELEM_W-1:0] elem);
        logic [ELEM_W-1:0] p;
        int                n;
        p    = ELEM_W'(prim);
        elem = '0;
        case (cfg_topo)
            TOPO_LINE_LIST:
            begin
                elem[0] = ELEM_W'(p * 2);
                elem[1] = ELEM_W'(p * 2 + 1);
                n = 2;
            end
            TOPO_LINE_STRIP:
            begin
                elem[0] = p;
                elem[1] = ELEM_W'(p + 1);
                n = 2;
            end
            TOPO_TRI_LIST:
            begin
                elem[0] = ELEM_W'(p * 3);
                elem[1] = ELEM_W'(p * 3 + 1);
                elem[2] = ELEM_W'(p * 3 + 2);
                n = 3;
            end
            default:
            begin
                // triangle strip: odd primitives swap first and third vertex
                elem[0] = p;
                elem[1] = ELEM_W'(p + 1);
                elem[2] = ELEM_W'(p + 2);
                if (p[0])
                begin
                    elem[0] = ELEM_W'(p + 2);
                    elem[2] = p;
                end
                n = 3;
            end
        endcase
        return n;
    endfunction

    // store slot read for one element, wrapping at the store depth
    function automatic int store_slot(input logic [ELEM_W-1:0] elem);
        return (int'(cfg_start) + int'(elem)) % STORE_DEPTH;
    endfunction

    // expected vertex beats of one accepted fetch
    function automatic void predict_primitive(input logic [PRIM_W-1:0] prim,
                                              input logic batch_start);
        logic [2:0][ELEM_W-1:0]  elem;
        logic [2:0][VALUE_W-1:0] vidx;
        logic [VALUE_W-1:0]      raw;
        logic [VALUE_W-1:0]      lo;
        logic [VALUE_W-1:0]      hi;
        vertex_beat_t            beat;
        int                      n;
        n    = prim_elements(prim, elem);
        vidx = '0;
        lo   = '0;
        hi   = '0;
        if (cfg_mode == MODE_NONE)
        begin
            // non-indexed: bounds read as zero, batch flag has no effect
            for (int i = 0; i < n; i++)
            begin
                vidx[i] = VALUE_W'(elem[i]) + cfg_base;
            end
        end
        else
        begin
            if (batch_start)
            begin
                run_min = '1;
                run_max = '0;
            end
            for (int i = 0; i < n; i++)
            begin
                raw = store_shadow[store_slot(elem[i])];
                if (cfg_mode == MODE_R16)
                begin
                    raw = raw & 32'h0000_FFFF;
                end
                if (raw < run_min) run_min = raw;
                if (raw > run_max) run_max = raw;
                vidx[i] = raw + cfg_base;
            end
            // bounds are taken after the whole primitive
            lo = run_min + cfg_base;
            hi = run_max + cfg_base;
        end
        for (int i = 0; i < n; i++)
        begin
            beat.vertex_index = vidx[i];
            beat.low_index    = lo;
            beat.high_index   = hi;
            beat.last_vertex  = (i == n - 1);
            pending_vertices.push_back(beat);
        end
    endfunction

    // index values biased toward the interesting corners
    function automatic logic [VALUE_W-1:0] random_word();
        logic [VALUE_W-1:0] w;
        case ($urandom_range(0, 7))
            0:       w = '0;
            1:       w = '1;
            2:       w = 32'h0000_FFFF;
            3:       w = 32'h0001_0000;
            4:       w = VALUE_W'($urandom_range(0, 255));
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // mostly full-range primitive numbers, some near zero
    function automatic logic [PRIM_W-1:0] pick_prim();
        logic [PRIM_W-1:0] p;
        if ($urandom_range(0, 3) == 0) p = PRIM_W'($urandom_range(0, 7));
        else                           p = PRIM_W'($urandom_range(0, 4095));
        return p;
    endfunction

    // offer one beat on the input channel and update the shadow on acceptance;
    // valid stays high afterwards so back-to-back beats need no second drive
    task automatic send_beat(input logic func, input logic [EADDR_W-1:0] addr,
                             input logic [VALUE_W-1:0] value,
                             input logic [PRIM_W-1:0] prim, input logic batch_start);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.func           <= func;
        in_ch.entry_address  <= addr;
        in_ch.entry_value    <= value;
        in_ch.prim_id        <= prim;
        in_ch.first_of_batch <= batch_start;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        beats_sent++;
        if (func == FUNC_LOAD)
        begin
            store_shadow[addr]  = value;
            store_written[addr] = 1'b1;
        end
        else
        begin
            predict_primitive(prim, batch_start);
        end
    endtask

    // load beat; the fetch-only fields carry noise
    task automatic load_entry(input logic [EADDR_W-1:0] addr, input logic [VALUE_W-1:0] value);
        send_beat(FUNC_LOAD, addr, value, PRIM_W'($urandom), 1'(($urandom)));
    endtask

    // fetch beat, preceded by loads of any store slot it would read unwritten
    task automatic fetch_prim(input logic [PRIM_W-1:0] prim, input logic batch_start);
        logic [2:0][ELEM_W-1:0] elem;
        int                     n;
        int                     slot;
        if (cfg_mode != MODE_NONE)
        begin
            n = prim_elements(prim, elem);
            for (int i = 0; i < n; i++)
            begin
                slot = store_slot(elem[i]);
                if (!store_written[slot])
                begin
                    load_entry(EADDR_W'(slot), random_word());
                end
            end
        end
        send_beat(FUNC_FETCH, EADDR_W'($urandom), VALUE_W'($urandom), prim, batch_start);
    endtask

    // drop valid, let every predicted beat drain, then cover a load still in flight
    task automatic wait_idle();
        int waited;
        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending_vertices.size() != 0 && waited < 4000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_vertices.size() != 0)
        begin
            report_mismatch("vertex beats never delivered", 32'd0, pending_vertices.size());
            pending_vertices.delete();
        end
        repeat (16) @(posedge clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // rewrite all four registers once the block is idle
    task automatic configure(input logic [1:0] topo, input logic [1:0] mode,
                             input logic [EADDR_W-1:0] start, input logic [VALUE_W-1:0] base);
        wait_idle();
        cfg_beat(CFG_TOPOLOGY, CFG_DATA_W'(topo));
        cfg_beat(CFG_INDEX_MODE, CFG_DATA_W'(mode));
        cfg_beat(CFG_START_ELEMENT, CFG_DATA_W'(start));
        cfg_beat(CFG_BASE_VERTEX, base);
        cfg_we    <= 1'b0;
        cfg_topo  = topo;
        cfg_mode  = mode;
        cfg_start = start;
        cfg_base  = base;
    endtask

    task automatic configure_random();
        logic [1:0]         mode;
        logic [EADDR_W-1:0] start;
        case ($urandom_range(0, 7))
            0, 1:    mode = MODE_NONE;
            2, 3, 4: mode = MODE_R16;
            5, 6:    mode = MODE_R32;
            default: mode = MODE_R32_ALIAS;
        endcase
        case ($urandom_range(0, 5))
            0:       start = '0;
            1:       start = '1;
            default: start = EADDR_W'($urandom);
        endcase
        configure(2'($urandom_range(0, 3)), mode, start, random_word());
    endtask

    // reset config first, then every topology non-indexed, all but triangle strip with a wrapping base
    task automatic test_non_indexed();
        fetch_prim(12'd5, 1'b1);
        configure(TOPO_LINE_LIST, MODE_NONE, 12'd0, 32'hFFFF_FFF0);
        fetch_prim(12'd0, 1'b1);
        fetch_prim(12'd4095, 1'b0);
        configure(TOPO_LINE_STRIP, MODE_NONE, 12'd4095, 32'hFFFF_FFF0);
        fetch_prim(12'd4095, 1'b1);
        configure(TOPO_TRI_LIST, MODE_NONE, 12'd0, 32'hFFFF_FFF0);
        fetch_prim(12'd4095, 1'b1);
        configure(TOPO_TRI_STRIP, MODE_NONE, 12'd0, 32'd0);
        fetch_prim(12'd0, 1'b0);
        fetch_prim(12'd4095, 1'b1);
    endtask

    // strip reads that wrap past the end of the store, every index width,
    // all-ones values taken as ordinary indices
    task automatic test_indexed_wrap();
        configure(TOPO_TRI_STRIP, MODE_R16, 12'd4094, 32'd0);
        load_entry(12'd4094, 32'hFFFF_FFFF);
        load_entry(12'd4095, 32'h1234_0000);
        load_entry(12'd0, 32'h0001_ABCD);
        load_entry(12'd1, 32'h0000_0000);
        // running bounds straight out of reset, no batch flag
        fetch_prim(12'd0, 1'b0);
        fetch_prim(12'd1, 1'b0);
        configure(TOPO_TRI_STRIP, MODE_R32, 12'd4094, 32'hFFFF_FFFF);
        fetch_prim(12'd1, 1'b1);
        fetch_prim(12'd0, 1'b0);
        configure(TOPO_LINE_STRIP, MODE_R32_ALIAS, 12'd4094, 32'h8000_0000);
        fetch_prim(12'd0, 1'b1);
        fetch_prim(12'd1, 1'b0);
    endtask

    // output held off for a long stretch while fetches keep coming
    task automatic test_output_hold();
        configure(TOPO_TRI_LIST, MODE_R32, EADDR_W'($urandom), random_word());
        hold_left = 120;
        repeat (8) fetch_prim(pick_prim(), 1'($urandom_range(0, 3) == 0));
    endtask

    // random config phases, mostly fetches with their loads, some stray loads
    task automatic test_random_traffic();
        int goal;
        int phase;
        goal  = beats_sent + 80;
        phase = 0;
        while (beats_sent < goal)
        begin
            configure_random();
            idle_on = (phase % 3 != 2);
            for (int k = 0; k < 24 && beats_sent < goal; k++)
            begin
                if ($urandom_range(0, 9) < 2) load_entry(EADDR_W'($urandom), random_word());
                else fetch_prim(pick_prim(), 1'($urandom_range(0, 3) == 0));
            end
            phase++;
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_tail_without_idle();
        idle_on = 1'b0;
        configure_random();
        repeat (12) fetch_prim(pick_prim(), 1'($urandom_range(0, 3) == 0));
    endtask

    // output ready: long hold when asked, else random stall bursts while idling is on
    initial
    begin : sink_ready
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // compare every accepted vertex beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_vertices.size() == 0)
            begin
                report_mismatch("vertex beat with nothing pending", out_ch.vertex_index, 32'd0);
            end
            else
            begin
                head_vertex = pending_vertices.pop_front();
                if (out_ch.vertex_index !== head_vertex.vertex_index)
                    report_mismatch("vertex_index", out_ch.vertex_index, head_vertex.vertex_index);
                if (out_ch.low_index !== head_vertex.low_index)
                    report_mismatch("low_index", out_ch.low_index, head_vertex.low_index);
                if (out_ch.high_index !== head_vertex.high_index)
                    report_mismatch("high_index", out_ch.high_index, head_vertex.high_index);
                if (out_ch.last_vertex !== head_vertex.last_vertex)
                    report_mismatch("last_vertex", 32'(out_ch.last_vertex),
                                    32'(head_vertex.last_vertex));
            end
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.func           = FUNC_LOAD;
        in_ch.entry_address  = '0;
        in_ch.entry_value    = '0;
        in_ch.prim_id        = '0;
        in_ch.first_of_batch = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_non_indexed();
        test_indexed_wrap();
        test_output_hold();
        test_random_traffic();
        test_tail_without_idle();
        wait_idle();

        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
